// ----- design/sirc20_pkg.sv -----
`default_nettype none

package sirc20_pkg;

    // Frame timing, in carrier periods.
    localparam logic [8:0] START_MARK_LEN = 9'd96;
    localparam logic [8:0] ONE_MARK_LEN   = 9'd48;
    localparam logic [8:0] UNIT_LEN       = 9'd24;
    localparam logic [8:0] GAP_LEN        = 9'd440;
    localparam logic [4:0] FRAME_BITS     = 5'd20;

    localparam int ADDR_W    = 13;
    localparam int CMD_W     = 7;
    localparam int CODE_W    = ADDR_W + CMD_W;
    localparam int CARRIER_W = 8;

    // Register reset values.
    localparam logic [ADDR_W-1:0]    ADDR_RESET  = 13'h1E3A;
    localparam logic [CARRIER_W-1:0] TOP_RESET   = 8'd24;
    localparam logic [CARRIER_W-1:0] MATCH_RESET = 8'd18;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_CARRIER_TOP    = 2'd1,
        REG_MARK_MATCH     = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_idx_t;

    // Input operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_START_MARK  = 6'b000010,
        PH_START_SPACE = 6'b000100,
        PH_BIT_MARK    = 6'b001000,
        PH_BIT_SPACE   = 6'b010000,
        PH_GAP         = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    device_address;
        logic [CARRIER_W-1:0] carrier_top;
        logic [CARRIER_W-1:0] mark_match;
    } cfg_t;

    typedef struct packed {
        logic busy_res;
        logic ir_out;
    } res_t;

endpackage

`default_nettype wire

// ----- design/sirc20_cfg.sv -----
`default_nettype none

module sirc20_cfg
    import sirc20_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [ADDR_W-1:0] cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= ADDR_RESET;
            cfg_reg.carrier_top    <= TOP_RESET;
            cfg_reg.mark_match     <= MATCH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data;
                REG_CARRIER_TOP:    cfg_reg.carrier_top    <= cfg_data[CARRIER_W-1:0];
                REG_MARK_MATCH:     cfg_reg.mark_match     <= cfg_data[CARRIER_W-1:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/sirc20_core.sv -----
`default_nettype none

module sirc20_core
    import sirc20_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             op,
    input  wire logic [CMD_W-1:0] command,
    input  wire cfg_t             cfg,
    output res_t                  res
);

    logic [CARRIER_W-1:0] carrier_count_reg, carrier_count_next;
    logic [CODE_W-1:0]    code_word_reg, code_word_next;
    phase_t               phase_reg, phase_next;
    logic [4:0]           bit_index_reg, bit_index_next;
    logic [8:0]           period_count_reg, period_count_next;
    logic                 second_frame_reg, second_frame_next;

    logic       in_mark;
    logic       cur_bit;
    logic [8:0] phase_len;
    logic [8:0] period_inc;
    logic [4:0] bit_inc;
    logic [CODE_W-1:0] code_shift;

    assign code_shift = code_word_reg >> bit_index_reg;
    assign cur_bit    = code_shift[0];
    assign in_mark    = (phase_reg == PH_START_MARK) || (phase_reg == PH_BIT_MARK);
    assign period_inc = period_count_reg + 9'd1;
    assign bit_inc    = bit_index_reg + 5'd1;

    // Output reflects the state before the tick; a request reports busy at once
    // and its level comes from the state before it, as for a tick.
    assign res = '{busy_res: (phase_reg != PH_IDLE) || (op == OP_REQUEST),
                   ir_out:   in_mark && (carrier_count_reg > cfg.mark_match)};

    always_comb
    begin
        unique case (phase_reg)
            PH_START_MARK: phase_len = START_MARK_LEN;
            PH_BIT_MARK:   phase_len = cur_bit ? ONE_MARK_LEN : UNIT_LEN;
            PH_GAP:        phase_len = GAP_LEN;
            default:       phase_len = UNIT_LEN;
        endcase
    end

    always_comb
    begin
        carrier_count_next = carrier_count_reg;
        code_word_next     = code_word_reg;
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        period_count_next  = period_count_reg;
        second_frame_next  = second_frame_reg;

        if (accept)
        begin
            if (op == OP_REQUEST)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    code_word_next     = {cfg.device_address, command};
                    carrier_count_next = '0;
                    phase_next         = PH_START_MARK;
                    bit_index_next     = '0;
                    period_count_next  = '0;
                    second_frame_next  = 1'b0;
                end
            end
            else if (carrier_count_reg == cfg.carrier_top)
            begin
                carrier_count_next = '0;
                if (phase_reg != PH_IDLE)
                begin
                    period_count_next = period_inc;
                    if (period_inc >= phase_len)
                    begin
                        period_count_next = '0;
                        unique case (phase_reg)
                            PH_START_MARK:  phase_next = PH_START_SPACE;
                            PH_START_SPACE: phase_next = PH_BIT_MARK;
                            PH_BIT_MARK:    phase_next = PH_BIT_SPACE;
                            PH_BIT_SPACE:
                            begin
                                if (bit_inc >= FRAME_BITS)
                                begin
                                    bit_index_next = '0;
                                    if (second_frame_reg)
                                    begin
                                        phase_next        = PH_IDLE;
                                        second_frame_next = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_GAP;
                                    end
                                end
                                else
                                begin
                                    bit_index_next = bit_inc;
                                    phase_next     = PH_BIT_MARK;
                                end
                            end
                            PH_GAP:
                            begin
                                second_frame_next = 1'b1;
                                bit_index_next    = '0;
                                phase_next        = PH_START_MARK;
                            end
                            default: phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
            else
            begin
                carrier_count_next = carrier_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_count_reg <= '0;
            code_word_reg     <= '0;
            phase_reg         <= PH_IDLE;
            bit_index_reg     <= '0;
            period_count_reg  <= '0;
            second_frame_reg  <= 1'b0;
        end
        else
        begin
            carrier_count_reg <= carrier_count_next;
            code_word_reg     <= code_word_next;
            phase_reg         <= phase_next;
            bit_index_reg     <= bit_index_next;
            period_count_reg  <= period_count_next;
            second_frame_reg  <= second_frame_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sirc20_outq.sv -----
`default_nettype none

module sirc20_outq
    import sirc20_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      can_push,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_data
);

    // Two-entry buffer: head register plus one skid entry.
    logic [1:0] count_reg, count_next;
    res_t       head_reg, head_next;
    res_t       skid_reg, skid_next;
    logic       pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    head_next = push_data;
                else
                    skid_next = push_data;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                // A push only happens below full, so exactly one entry is held.
                head_next = push_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ----- design/sirc20_ir_transmitter_top.sv -----
// Channel   Direction  Signals                       Contents
// s_axis    in         tvalid tready tdata tuser     command, op (tick or send request)
// m_axis    out        tvalid tready tdata           ir_out, busy_res
// cfg       in         cfg_valid cfg_ready addr data device_address, carrier_top, mark_match
//
// Every input transaction produces one result, registered in the result buffer; a new item is taken
// in every cycle as long as the two-entry result buffer is not full.
// The transmit state is updated at the clock edge that accepts an item.
// Reset (rst_n, asynchronous) returns to idle with the register defaults loaded.
// A stalled result port fills the buffer and then drops s_axis_tready.
`default_nettype none

module sirc20_ir_transmitter_top
    import sirc20_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Input stream: one timer tick or one send request per transaction.
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [6:0] command, [7] zero fill
    input  wire logic              s_axis_tuser,   // [0] op

    // Result stream: drive level and busy flag for each input transaction.
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [0] ir_out, [1] busy_res, [7:2] zero

    // Configuration writes.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t step_res;
    res_t out_res;
    logic accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    sirc20_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The transmit sequencer: carrier counter, phase, bit and period counters.
    sirc20_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (s_axis_tuser),
        .command (s_axis_tdata[CMD_W-1:0]),
        .cfg     (cfg),
        .res     (step_res)
    );

    // Results are registered here, which decouples input ready from output ready.
    sirc20_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .can_push  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {6'b0, out_res.busy_res, out_res.ir_out};

endmodule

`default_nettype wire

// ----- design/sirc20_chk.sv -----
`default_nettype none

module sirc20_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // No result is presented while in reset.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The emitter can only be on while a transmission is running.
    a_ir_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("ir_out high while not busy");

    // Input back-pressure only comes from results waiting downstream.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Fill bits are zero.
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'b0))
        else $error("nonzero fill bits in result");

endmodule

bind sirc20_ir_transmitter_top sirc20_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
